/* hdl/bfau_pkg.sv */
package bfau_pkg;

  localparam logic [10:0] ExpSpecial = 11'h7ff;
  localparam logic [10:0] ExpTop = 11'h7fe;
  localparam int signed ExpBias = 1023;

  localparam logic [2:0] CmdAdd = 3'd0;
  localparam logic [2:0] CmdSub = 3'd1;
  localparam logic [2:0] CmdMul = 3'd2;
  localparam logic [2:0] CmdDiv = 3'd3;
  localparam logic [2:0] CmdCmp = 3'd4;

  // request to the rounding stage
  typedef struct packed {
    logic        sign;
    logic [13:0] expo;
    logic [63:0] sig;
  } round_req_t;

endpackage

/* hdl/binary64_float_arith_unit.sv */
// binary64 add, subtract, multiply, divide and compare
// slave channel: s_axis_tdata carries command, operand_a, operand_b
// master channel: m_axis_tdata carries result_bits and order
// one request is taken at a time; s_axis_tready is low until its result
// has been taken from the output register, and the next request can be
// accepted in the cycle after the result handshake
// work from request handshake to result handshake:
//   compare, unused commands and special operands: result registered at accept
//   add/subtract: alignment shift (up to 64 bits), add, then rounding
//   normalize and underflow shifts (up to 62 and 63 bits)
//   multiply: 53 shift-add steps, then rounding
//   divide: 63 restoring quotient steps, then rounding
// each subnormal operand is first normalized by shifting out the leading zeros of its fraction;
// an underflowing result is denormalized by up to 63 single-bit shifts, or straight to the sticky bit
// all long work is iterative, one shift or add/subtract step per cycle
// reset clears the sequencer and drops any pending result
// a stalled receiver holds the result in place; no new request is taken
module binary64_float_arith_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] command, [66:3] operand_a, [130:67] operand_b, zero fill
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] result_bits, [65:64] order, zero fill
  output logic [71:0]  m_axis_tdata
);

  typedef enum logic [3:0] {
    SIdle, SNormA, SNormB, SAlign, SAddOp, SMul, SDiv, SRound, SOut
  } state_e;

  state_e      state_q;
  logic [2:0]  cmd_q;
  logic        sa_q, sb_q;
  logic [52:0] ma_q, mb_q;
  logic [13:0] ea_q, eb_q;
  logic [63:0] acc_q;     // alignment value, product high, quotient
  logic [63:0] aux_q;     // multiplier bits, remainder
  logic [6:0]  cnt_q;
  logic [63:0] res_q;
  logic [1:0]  ord_q;
  logic        ovalid_q;

  logic                 rstart_q;
  bfau_pkg::round_req_t rreq_q;
  logic                 rdone;
  logic [63:0]          rres;

  logic [2:0]  icmd;
  logic [63:0] ia, ib;
  assign icmd = s_axis_tdata[2:0];
  assign ia   = s_axis_tdata[66:3];
  assign ib   = s_axis_tdata[130:67];

  function automatic logic nan_f(input logic [63:0] x);
    return x[62:52] == bfau_pkg::ExpSpecial && x[51:0] != 52'd0;
  endfunction
  function automatic logic inf_f(input logic [63:0] x);
    return x[62:52] == bfau_pkg::ExpSpecial && x[51:0] == 52'd0;
  endfunction
  function automatic logic zero_f(input logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction
  function automatic logic [63:0] key_f(input logic [63:0] x);
    return x[63] ? ~x : {1'b1, x[62:0]};
  endfunction

  // special-case decode at accept time
  logic        sp_hit;
  logic [63:0] sp_res;
  logic [1:0]  sp_ord;
  logic        esa, esb, xs;
  logic [63:0] ka, kb;
  always_comb begin
    esa = ia[63];
    esb = ib[63] ^ (icmd == bfau_pkg::CmdSub);
    xs  = ia[63] ^ ib[63];
    ka  = key_f(ia);
    kb  = key_f(ib);
    sp_hit = 1'b1;
    sp_res = 64'd0;
    sp_ord = 2'd0;
    case (icmd)
      bfau_pkg::CmdAdd, bfau_pkg::CmdSub: begin
        if (nan_f(ia) || nan_f(ib)) sp_res = {esa, bfau_pkg::ExpSpecial, 52'd1};
        else if (inf_f(ia) && inf_f(ib))
          sp_res = (esa != esb) ? {esa, bfau_pkg::ExpSpecial, 52'd1}
                                : {esa, bfau_pkg::ExpSpecial, 52'd0};
        else if (inf_f(ia)) sp_res = {esa, bfau_pkg::ExpSpecial, 52'd0};
        else if (inf_f(ib)) sp_res = {esb, bfau_pkg::ExpSpecial, 52'd0};
        else if (zero_f(ia) && zero_f(ib)) sp_res = {esa & esb, 63'd0};
        else if (zero_f(ia)) sp_res = {esb, ib[62:0]};
        else if (zero_f(ib)) sp_res = ia;
        else sp_hit = 1'b0;
      end
      bfau_pkg::CmdMul: begin
        if (nan_f(ia) || nan_f(ib)) sp_res = {xs, bfau_pkg::ExpSpecial, 52'd1};
        else if (inf_f(ia) || inf_f(ib))
          sp_res = (zero_f(ia) || zero_f(ib)) ? {xs, bfau_pkg::ExpSpecial, 52'd1}
                                              : {xs, bfau_pkg::ExpSpecial, 52'd0};
        else if (zero_f(ia) || zero_f(ib)) sp_res = {xs, 63'd0};
        else sp_hit = 1'b0;
      end
      bfau_pkg::CmdDiv: begin
        if (nan_f(ia) || nan_f(ib)) sp_res = {xs, bfau_pkg::ExpSpecial, 52'd1};
        else if (inf_f(ia) && inf_f(ib)) sp_res = {xs, bfau_pkg::ExpSpecial, 52'd1};
        else if (zero_f(ib))
          sp_res = zero_f(ia) ? {xs, bfau_pkg::ExpSpecial, 52'd1}
                              : {xs, bfau_pkg::ExpSpecial, 52'd0};
        else if (inf_f(ia)) sp_res = {xs, bfau_pkg::ExpSpecial, 52'd0};
        else if (inf_f(ib) || zero_f(ia)) sp_res = {xs, 63'd0};
        else sp_hit = 1'b0;
      end
      bfau_pkg::CmdCmp: begin
        sp_ord = (ka < kb) ? 2'b11 : ((ka == kb) ? 2'b00 : 2'b01);
      end
      default: ;
    endcase
  end

  // shared datapath helpers
  logic        swap_w;
  logic [63:0] bigA, bigB, sum_w;
  logic [64:0] padd;
  logic [63:0] rsub;
  logic        rge;
  always_comb begin
    swap_w = ($signed(eb_q) > $signed(ea_q)) || (eb_q == ea_q && mb_q > ma_q);
    bigA   = {2'b0, ma_q, 9'd0};
    bigB   = acc_q;
    sum_w  = (sa_q == sb_q) ? bigA + bigB : bigA - bigB;
    padd   = {1'b0, acc_q} + (aux_q[0] ? {12'd0, ma_q} : 65'd0);
    rge    = aux_q >= {11'd0, mb_q};
    rsub   = rge ? aux_q - {11'd0, mb_q} : aux_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ovalid_q <= 1'b0;
      rstart_q <= 1'b0;
    end else begin
      // rounding starts once add, multiply or divide hands over its value
      rstart_q <= (state_q == SAddOp && sum_w != 64'd0) ||
                  (state_q == SMul && cnt_q == 7'd53) ||
                  (state_q == SDiv && cnt_q == 7'd63);
      case (state_q)
        SIdle: begin
          if (s_axis_tvalid) begin
            cmd_q <= icmd;
            if (sp_hit || icmd > bfau_pkg::CmdDiv) begin
              res_q    <= sp_res;
              ord_q    <= sp_ord;
              ovalid_q <= 1'b1;
              state_q  <= SOut;
            end else begin
              if (icmd == bfau_pkg::CmdMul || icmd == bfau_pkg::CmdDiv) begin
                sa_q <= xs;
                sb_q <= xs;
              end else begin
                sa_q <= esa;
                sb_q <= esb;
              end
              ma_q <= {ia[62:52] != 11'd0, ia[51:0]};
              mb_q <= {ib[62:52] != 11'd0, ib[51:0]};
              ea_q <= (ia[62:52] == 11'd0) ? 14'd1 : {3'd0, ia[62:52]};
              eb_q <= (ib[62:52] == 11'd0) ? 14'd1 : {3'd0, ib[62:52]};
              state_q <= SNormA;
            end
          end
        end
        SNormA: begin
          if (!ma_q[52]) begin
            ma_q <= ma_q << 1;
            ea_q <= ea_q - 14'd1;
          end else state_q <= SNormB;
        end
        SNormB: begin
          if (!mb_q[52]) begin
            mb_q <= mb_q << 1;
            eb_q <= eb_q - 14'd1;
          end else begin
            case (cmd_q)
              bfau_pkg::CmdMul: begin
                cnt_q   <= 7'd0;
                acc_q   <= 64'd0;
                aux_q   <= {11'd0, mb_q};
                state_q <= SMul;
              end
              bfau_pkg::CmdDiv: begin
                cnt_q   <= 7'd0;
                acc_q   <= 64'd0;
                aux_q   <= {11'd0, ma_q};
                state_q <= SDiv;
              end
              default: begin
                state_q <= SAlign;
                if (swap_w) begin
                  ma_q <= mb_q; mb_q <= ma_q;
                  ea_q <= eb_q; eb_q <= ea_q;
                  sa_q <= sb_q; sb_q <= sa_q;
                  acc_q <= {2'b0, ma_q, 9'd0};
                  cnt_q <= (eb_q - ea_q > 14'd64) ? 7'd64 : 7'(eb_q - ea_q);
                end else begin
                  acc_q <= {2'b0, mb_q, 9'd0};
                  cnt_q <= (ea_q - eb_q > 14'd64) ? 7'd64 : 7'(ea_q - eb_q);
                end
              end
            endcase
          end
        end
        SAlign: begin
          // one-bit jamming shift per cycle
          if (cnt_q != 7'd0) begin
            acc_q <= {1'b0, acc_q[63:2], acc_q[1] | acc_q[0]};
            cnt_q <= cnt_q - 7'd1;
          end else state_q <= SAddOp;
        end
        SAddOp: begin
          if (sum_w == 64'd0) begin
            res_q    <= 64'd0;
            ord_q    <= 2'd0;
            ovalid_q <= 1'b1;
            state_q  <= SOut;
          end else begin
            rreq_q.sign <= sa_q;
            rreq_q.expo <= ea_q + 14'd1;
            rreq_q.sig  <= sum_w;
            state_q     <= SRound;
          end
        end
        SMul: begin
          // shift-add: product bits fall out of the low end into aux top
          if (cnt_q != 7'd53) begin
            acc_q <= padd[64:1];
            aux_q <= {padd[0], aux_q[63:1]};
            cnt_q <= cnt_q + 7'd1;
          end else begin
            // product 106 bits = acc[52:0] : aux[63:11]; keep bits 105..43 plus a sticky bit
            rreq_q.sign <= sa_q;
            rreq_q.expo <= ea_q + eb_q - 14'(bfau_pkg::ExpBias);
            rreq_q.sig  <= {acc_q[52:0], aux_q[63:54],
                            aux_q[53] | (aux_q[52:11] != 42'd0)};
            state_q     <= SRound;
          end
        end
        SDiv: begin
          if (cnt_q != 7'd63) begin
            acc_q <= {acc_q[62:0], rge};
            aux_q <= rsub << 1;
            cnt_q <= cnt_q + 7'd1;
          end else begin
            rreq_q.sign <= sa_q;
            rreq_q.expo <= ea_q - eb_q + 14'(bfau_pkg::ExpBias);
            rreq_q.sig  <= {acc_q[63:1], acc_q[0] | (aux_q != 64'd0)};
            state_q     <= SRound;
          end
        end
        SRound: begin
          if (rdone) begin
            res_q    <= rres;
            ord_q    <= 2'd0;
            ovalid_q <= 1'b1;
            state_q  <= SOut;
          end
        end
        SOut: begin
          if (m_axis_tready) begin
            ovalid_q <= 1'b0;
            state_q  <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  bfau_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (rstart_q),
    .req_i    (rreq_q),
    .done_o   (rdone),
    .result_o (rres)
  );

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, ord_q, res_q};

endmodule

/* hdl/bfau_round.sv */
// normalize, denormalize on underflow, then round and pack, overflowing to infinity; one shift step per cycle
module bfau_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  bfau_pkg::round_req_t req_i,
  output logic                 done_o,
  output logic [63:0]          result_o
);

  typedef enum logic [1:0] {RIdle, RNorm, RDenorm, RPack} rstate_e;

  rstate_e     state_q;
  logic        sign_q;
  logic [13:0] expo_q;
  logic [63:0] sig_q;
  logic [63:0] result_q;
  logic        done_q;

  logic [63:0] q_w;
  logic [53:0] qr_w;
  logic [52:0] qf_w;
  logic [13:0] ef_w;

  always_comb begin
    qr_w = {1'b0, sig_q[62:10]} + 54'(sig_q[9]);
    if (sig_q[9:0] == 10'h200) qr_w[0] = 1'b0;
    ef_w = expo_q;
    qf_w = qr_w[52:0];
    if (qr_w[53]) begin
      qf_w = qr_w[53:1];
      ef_w = expo_q + 14'd1;
    end
    q_w = 64'(qf_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == RPack);
      case (state_q)
        RIdle: begin
          if (start_i) begin
            sign_q <= req_i.sign;
            if (req_i.sig[63]) begin
              sig_q  <= {1'b0, req_i.sig[63:2], req_i.sig[1] | req_i.sig[0]};
              expo_q <= req_i.expo + 14'd1;
            end else begin
              sig_q  <= req_i.sig;
              expo_q <= req_i.expo;
            end
            state_q <= RNorm;
          end
        end
        RNorm: begin
          if (!sig_q[62]) begin
            sig_q  <= sig_q << 1;
            expo_q <= expo_q - 14'd1;
          end else state_q <= RDenorm;
        end
        RDenorm: begin
          if ($signed(expo_q) < -14'sd62) begin
            // a shift of 64 or more leaves only the sticky bit
            sig_q  <= {63'd0, sig_q != 64'd0};
            expo_q <= 14'd1;
          end else if ($signed(expo_q) < 14'sd1) begin
            sig_q  <= {1'b0, sig_q[63:2], sig_q[1] | sig_q[0]};
            expo_q <= expo_q + 14'd1;
          end else state_q <= RPack;
        end
        RPack: begin
          if ($signed(ef_w) > $signed({3'b0, bfau_pkg::ExpTop}))
            result_q <= {sign_q, bfau_pkg::ExpSpecial, 52'd0};
          else if (!q_w[52]) result_q <= {sign_q, 11'd0, q_w[51:0]};
          else result_q <= {sign_q, ef_w[10:0], q_w[51:0]};
          state_q <= RIdle;
        end
        default: state_q <= RIdle;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
